/* design/fmp_pkg.sv */
`default_nettype none

package fmp_pkg;

    // Default sizes of the arithmetic and of the term number
    localparam int VALUE_WIDTH_DEF = 64;
    localparam int INDEX_WIDTH_DEF = 32;

    // Fixed port widths
    localparam int FIB_PORT_W   = 64;
    localparam int INDEX_PORT_W = 32;

    // Top level sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_BIT,
        S_START,
        S_WAIT,
        S_COMMIT,
        S_DONE
    } state_t;

    // Matrix product in progress
    typedef enum logic {
        OP_MUL,     // acc = acc * q
        OP_SQR      // q = q * q
    } op_t;

    // Partial product of one split multiplication
    typedef enum logic [1:0] {
        PART_LL,    // lo * lo
        PART_LH,    // lo * hi, shifted up
        PART_HL     // hi * lo, shifted up
    } part_t;

    // Control into the dot product unit
    typedef struct packed {
        logic start;
    } dot_ctrl_t;

    // Status back from the dot product unit
    typedef struct packed {
        logic busy;
        logic done;
    } dot_stat_t;

endpackage

`default_nettype wire

/* design/fmp_dot.sv */
`default_nettype none

// Two-term dot product a0*b0 + a1*b1 modulo 2^VALUE_WIDTH on one narrow
// multiplier. Each product is split into lo/hi halves; only the three
// partial products that reach the low VALUE_WIDTH bits are formed.
module fmp_dot
    import fmp_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire dot_ctrl_t              ctrl,
    input  wire logic [VALUE_WIDTH-1:0] a0,
    input  wire logic [VALUE_WIDTH-1:0] b0,
    input  wire logic [VALUE_WIDTH-1:0] a1,
    input  wire logic [VALUE_WIDTH-1:0] b1,
    output dot_stat_t                   stat,
    output logic      [VALUE_WIDTH-1:0] sum
);

    localparam int LO_W = (VALUE_WIDTH + 1) / 2;
    localparam int HI_W = VALUE_WIDTH - LO_W;
    localparam int PR_W = 2 * LO_W;

    logic [VALUE_WIDTH-1:0] a0_reg, b0_reg, a1_reg, b1_reg;
    logic [VALUE_WIDTH-1:0] acc_reg;
    part_t                  part_reg;
    logic                   term_reg;
    logic                   issue_reg;
    logic                   pvalid_reg;
    logic                   pshift_reg;
    logic                   done_reg;
    logic [PR_W-1:0]        prod_reg;

    logic [VALUE_WIDTH-1:0] opa, opb;
    logic [LO_W-1:0]        mul_a, mul_b;
    logic [VALUE_WIDTH-1:0] addend;
    logic                   last_issue;

    // Operand and half selection for the current partial product
    always_comb
    begin
        opa = term_reg ? a1_reg : a0_reg;
        opb = term_reg ? b1_reg : b0_reg;
        case (part_reg)
            PART_LL:
            begin
                mul_a = opa[LO_W-1:0];
                mul_b = opb[LO_W-1:0];
            end
            PART_LH:
            begin
                mul_a = opa[LO_W-1:0];
                mul_b = LO_W'(opb >> LO_W);
            end
            PART_HL:
            begin
                mul_a = LO_W'(opa >> LO_W);
                mul_b = opb[LO_W-1:0];
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign last_issue = term_reg && (part_reg == PART_HL);

    // Registered product aligned into the result window
    assign addend = pshift_reg ? {prod_reg[HI_W-1:0], {LO_W{1'b0}}}
                               : prod_reg[VALUE_WIDTH-1:0];

    // Sequencing of the six partial products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_reg  <= 1'b0;
            pvalid_reg <= 1'b0;
            done_reg   <= 1'b0;
            part_reg   <= PART_LL;
            term_reg   <= 1'b0;
        end
        else
        begin
            done_reg <= pvalid_reg && !issue_reg;
            if (ctrl.start)
            begin
                issue_reg  <= 1'b1;
                pvalid_reg <= 1'b0;
                part_reg   <= PART_LL;
                term_reg   <= 1'b0;
            end
            else
            begin
                pvalid_reg <= issue_reg;
                if (issue_reg)
                begin
                    case (part_reg)
                        PART_LL: part_reg <= PART_LH;
                        PART_LH: part_reg <= PART_HL;
                        default:
                        begin
                            part_reg <= PART_LL;
                            term_reg <= 1'b1;
                        end
                    endcase
                    if (last_issue)
                        issue_reg <= 1'b0;
                end
            end
        end
    end

    // Operand latch, multiplier and accumulator
    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            a0_reg  <= a0;
            b0_reg  <= b0;
            a1_reg  <= a1;
            b1_reg  <= b1;
            acc_reg <= '0;
        end
        else
        begin
            if (issue_reg)
            begin
                prod_reg   <= mul_a * mul_b;
                pshift_reg <= (part_reg != PART_LL);
            end
            if (pvalid_reg)
                acc_reg <= acc_reg + addend;
        end
    end

    assign stat.busy = issue_reg || pvalid_reg;
    assign stat.done = done_reg;
    assign sum       = acc_reg;

endmodule

`default_nettype wire

/* design/fibonacci_matrix_power_top.sv */
`default_nettype none

// Fibonacci term by 2x2 matrix exponentiation. A transaction on the input
// carries a signed term number; one result transaction returns F(n) modulo
// 2^VALUE_WIDTH (F(1) = F(2) = 1), zero-extended to 64 bits. For n <= 0 the
// value is all ones and invalid is set. Q = [[0,1],[1,1]] is raised to n-2 by
// square-and-multiply, least significant exponent bit first. Every matrix
// product is four dot products on the single split multiplier in fmp_dot,
// followed by a commit state. An exponent bit passes through a decision
// state and costs one product (bit clear) or two (bit set), and the top bit
// skips its square. For n <= 2 the sequencer goes from idle straight to its
// done state without forming a product. The block takes one item at a time
// and is ready again in the cycle after its result is loaded; a finished
// result waits in the output register while the next item enters.
module fibonacci_matrix_power_top
    import fmp_pkg::*;
#(
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int INDEX_WIDTH = INDEX_WIDTH_DEF
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic [INDEX_PORT_W-1:0] index,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic      [FIB_PORT_W-1:0]   fib_value,
    output logic                         invalid
);

    localparam int EXP_W = INDEX_WIDTH - 1;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0] e00;
        logic [VALUE_WIDTH-1:0] e01;
        logic [VALUE_WIDTH-1:0] e10;
        logic [VALUE_WIDTH-1:0] e11;
    } mat_t;

    localparam logic [VALUE_WIDTH-1:0] ONE  = VALUE_WIDTH'(1);
    localparam logic [VALUE_WIDTH-1:0] ZERO = '0;

    state_t                 state_reg, state_next;
    op_t                    op_reg;
    logic [1:0]             ent_reg;
    logic [EXP_W-1:0]       exp_reg;
    mat_t                   acc_reg, q_reg, tmp_reg;
    logic [VALUE_WIDTH-1:0] res_reg;
    logic                   res_inv_reg;
    logic                   out_valid_reg;
    logic [VALUE_WIDTH-1:0] fib_reg;
    logic                   inv_reg;

    logic [INDEX_WIDTH-1:0] raw;
    logic                   bad_index;
    logic                   small_index;
    logic                   in_fire;
    logic                   load_out;
    logic                   last_sqr;
    mat_t                   xm;
    logic [VALUE_WIDTH-1:0] x0, x1, y0, y1;
    dot_ctrl_t              dot_ctrl;
    dot_stat_t              dot_stat;
    logic [VALUE_WIDTH-1:0] dot_sum;

    // Input classification
    assign raw         = index[INDEX_WIDTH-1:0];
    assign bad_index   = raw[INDEX_WIDTH-1] || (raw == '0);
    assign small_index = (raw <= INDEX_WIDTH'(2));
    assign in_fire     = in_valid && in_ready;
    assign last_sqr    = ((exp_reg >> 1) == '0);

    // Dot product operands for entry (i, j) of X * q
    always_comb
    begin
        xm = (op_reg == OP_SQR) ? q_reg : acc_reg;
        x0 = ent_reg[1] ? xm.e10 : xm.e00;
        x1 = ent_reg[1] ? xm.e11 : xm.e01;
        y0 = ent_reg[0] ? q_reg.e01 : q_reg.e00;
        y1 = ent_reg[0] ? q_reg.e11 : q_reg.e10;
    end

    fmp_dot #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_dot (
        .clk  (clk),
        .rst_n(rst_n),
        .ctrl (dot_ctrl),
        .a0   (x0),
        .b0   (y0),
        .a1   (x1),
        .b1   (y1),
        .stat (dot_stat),
        .sum  (dot_sum)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (in_valid)
                    state_next = (bad_index || small_index) ? S_DONE : S_BIT;
            S_BIT:
                state_next = (exp_reg == '0) ? S_DONE : S_START;
            S_START:
                state_next = S_WAIT;
            S_WAIT:
                if (dot_stat.done)
                    state_next = (ent_reg == 2'd3) ? S_COMMIT : S_START;
            S_COMMIT:
                if (op_reg == OP_MUL && !last_sqr)
                    state_next = S_START;
                else
                    state_next = S_BIT;
            S_DONE:
                if (!out_valid_reg || out_ready)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // Control outputs
    always_comb
    begin
        in_ready       = 1'b0;
        dot_ctrl.start = 1'b0;
        load_out       = 1'b0;
        case (state_reg)
            S_IDLE:  in_ready       = 1'b1;
            S_START: dot_ctrl.start = 1'b1;
            S_DONE:  load_out       = !out_valid_reg || out_ready;
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_MUL;
            ent_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_BIT:
                begin
                    ent_reg <= '0;
                    op_reg  <= exp_reg[0] ? OP_MUL : OP_SQR;
                end
                S_WAIT:
                    if (dot_stat.done)
                        ent_reg <= ent_reg + 2'd1;
                S_COMMIT:
                    op_reg <= OP_SQR;
                default: ;
            endcase
        end
    end

    // Matrices, exponent and result
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
                if (in_fire)
                begin
                    exp_reg     <= EXP_W'(raw - INDEX_WIDTH'(2));
                    acc_reg     <= '{e00: ONE,  e01: ZERO, e10: ZERO, e11: ONE};
                    q_reg       <= '{e00: ZERO, e01: ONE,  e10: ONE,  e11: ONE};
                    res_inv_reg <= bad_index;
                    res_reg     <= bad_index ? {VALUE_WIDTH{1'b1}} : ONE;
                end
            S_BIT:
                if (exp_reg == '0)
                    res_reg <= acc_reg.e01 + acc_reg.e11;
            S_WAIT:
                if (dot_stat.done)
                begin
                    case (ent_reg)
                        2'd0:    tmp_reg.e00 <= dot_sum;
                        2'd1:    tmp_reg.e01 <= dot_sum;
                        2'd2:    tmp_reg.e10 <= dot_sum;
                        default: tmp_reg.e11 <= dot_sum;
                    endcase
                end
            S_COMMIT:
                if (op_reg == OP_MUL)
                begin
                    acc_reg <= tmp_reg;
                    if (last_sqr)
                        exp_reg <= '0;
                end
                else
                begin
                    q_reg   <= tmp_reg;
                    exp_reg <= exp_reg >> 1;
                end
            default: ;
        endcase
        if (load_out)
        begin
            fib_reg <= res_reg;
            inv_reg <= res_inv_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign fib_value = FIB_PORT_W'(fib_reg);
    assign invalid   = inv_reg;

    // Checks
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        dot_ctrl.start |=> dot_stat.busy)
        else $error("dot unit did not start");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> (state_reg != S_IDLE))
        else $error("accepted transaction left sequencer idle");

    a_load_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> out_valid_reg)
        else $error("result loaded without valid");

    a_no_start_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        dot_stat.busy |-> !dot_ctrl.start)
        else $error("dot unit restarted while busy");

    a_done_only_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        dot_stat.done |-> (state_reg == S_WAIT))
        else $error("dot result arrived outside wait state");

endmodule

`default_nettype wire
